FILE: hw/rtl/particle_pool_update_core_macros.svh
// Assertion macros shared by the particle pool RTL.
`ifndef PARTICLE_POOL_UPDATE_CORE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPU_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PPU_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ppu_pkg.sv
// Types, codes and helpers for the particle pool update core.
package ppu_pkg;

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_SPAWN_LIFE   = 3'd0,
        CFG_SPAWN_RADIUS = 3'd1,
        CFG_LAUNCH_SPEED = 3'd2,
        CFG_SPEED_DECAY  = 3'd3,
        CFG_FADE_STEP    = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] RST_SPAWN_LIFE   = 16'd32768;
    localparam logic [15:0] RST_SPAWN_RADIUS = 16'd2560;
    localparam logic [11:0] RST_LAUNCH_SPEED = 12'd2560;
    localparam logic [15:0] RST_SPEED_DECAY  = 16'd58982;
    localparam logic [11:0] RST_FADE_STEP    = 12'd205;

    localparam logic signed [21:0] POS_MAX = 22'sd524287;
    localparam logic signed [21:0] POS_MIN = -22'sd524288;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SQ, ST_SUM, ST_ROOT, ST_DIVX, ST_DIVY,
        ST_POSM, ST_POSS, ST_VELM, ST_VDIVX, ST_VDIVY, ST_SCAN, ST_WRITE,
        ST_TICK, ST_READ, ST_RDATA, ST_DONE
    } t_state;

    typedef enum logic {
        MATH_SQRT = 1'b0,
        MATH_DIV  = 1'b1
    } t_math_op;

    typedef struct packed {
        logic     start;
        t_math_op op;
    } t_math_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_math_sts;

    typedef struct packed {
        logic [15:0]        life;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [13:0] vel_x;
        logic signed [13:0] vel_y;
        logic [11:0]        red;
        logic [11:0]        green;
        logic [11:0]        blue;
    } t_entry;

    typedef struct packed {
        logic [5:0]         slot;
        logic               alive;
        logic [15:0]        life;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic [11:0]        red;
        logic [11:0]        green;
        logic [11:0]        blue;
        logic [5:0]         draw;
    } t_result;

    function automatic logic signed [19:0] sat_pos(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX[19:0];
        end else if (v < POS_MIN) begin
            r = POS_MIN[19:0];
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/particle_pool_update_core.sv
// Top level of the particle pool: sequencer, spawn datapath, pool memory and output stage.
//
//  channel   signals                                  direction
//  -------   ---------------------------------------  ---------
//  input     i_valid / o_ready, i_op .. i_rand_blue   in
//  result    o_valid / i_ready, o_slot .. o_draw_start out
//  config    i_cfg_valid / o_cfg_ready, index, data   in
//
// After reset a clearing pass writes POOL_SIZE zero entries, one per cycle; no
// transaction is taken on the input channel until it ends (config is always taken).
// Tick: one memory read and one write-back per slot.
// Spawn: up to 6 passes of shared sqrt/divide work (16 or 32 steps each), then a
// search of up to POOL_SIZE slots for a free one and 1 write.
// Read: one memory read. Each item then waits in a done state until the result
// register is free; one item is in work at a time.
`include "particle_pool_update_core_macros.svh"

module particle_pool_update_core #(
    parameter int POOL_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [15:0]        i_time_step,
    input  logic [5:0]         i_slot_index,
    input  logic signed [19:0] i_emitter_x,
    input  logic signed [19:0] i_emitter_y,
    input  logic signed [15:0] i_rand_x,
    input  logic signed [15:0] i_rand_y,
    input  logic [11:0]        i_rand_red,
    input  logic [11:0]        i_rand_green,
    input  logic [11:0]        i_rand_blue,
    // results
    output logic               o_valid,
    input  logic               i_ready,
    output logic [5:0]         o_slot,
    output logic               o_alive,
    output logic [15:0]        o_life_left,
    output logic signed [19:0] o_pos_x,
    output logic signed [19:0] o_pos_y,
    output logic [11:0]        o_red,
    output logic [11:0]        o_green,
    output logic [11:0]        o_blue,
    output logic [5:0]         o_draw_start,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int IW = $clog2(POOL_SIZE + 1);
    localparam int DW = $bits(ppu_pkg::t_entry);

    // ---------------------------------------------------------------- state
    ppu_pkg::t_state   r_state, n_state;
    logic [AW-1:0]     r_hint;
    logic              r_mwait;
    logic              r_out_valid;
    ppu_pkg::t_result  r_out;
    ppu_pkg::t_result  r_res;

    // config registers
    logic [15:0] r_cfg_life;
    logic [15:0] r_cfg_radius;
    logic [11:0] r_cfg_launch;
    logic [15:0] r_cfg_decay;
    logic [11:0] r_cfg_fade;

    // captured item
    logic [15:0]        r_dt;
    logic [5:0]         r_sidx;
    logic signed [19:0] r_ex;
    logic signed [19:0] r_ey;
    logic               r_sx;
    logic               r_sy;
    logic [15:0]        r_ax;
    logic [15:0]        r_ay;

    // spawn datapath
    logic               r_clamped;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic [31:0]        r_n2;
    logic [15:0]        r_root;
    logic [31:0]        r_prx;
    logic [31:0]        r_pry;
    logic [27:0]        r_numx;
    logic [27:0]        r_numy;
    ppu_pkg::t_entry    r_ent;
    logic [AW-1:0]      r_slot;

    // memory walk (clear, scan, tick)
    logic [IW-1:0] r_idx;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_paddr;
    logic          r_pend;
    logic [IW-1:0] r_chk;

    // ---------------------------------------------------------------- nets
    logic               in_acc;
    logic               out_free;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    ppu_pkg::t_entry    mem_wdata;
    ppu_pkg::t_entry    mem_rdata;
    ppu_pkg::t_entry    tick_ent;
    ppu_pkg::t_math_req math_req;
    ppu_pkg::t_math_sts math_sts;
    logic [31:0]        math_a;
    logic [15:0]        math_b;
    logic [31:0]        math_res;
    logic               math_state;
    logic               scan_last;
    logic               scan_hit;
    logic [AW-1:0]      addr_wrap;
    logic [17:0]        mag_px;
    logic [17:0]        mag_py;
    logic signed [21:0] sum_px;
    logic signed [21:0] sum_py;
    logic [15:0]        abs_rx;
    logic [15:0]        abs_ry;
    ppu_pkg::t_result   res_idle;

    assign in_acc    = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign scan_hit  = r_pend && (mem_rdata.life == 16'd0);
    assign scan_last = r_pend && (r_chk == IW'(POOL_SIZE - 1));
    assign addr_wrap = (r_addr == AW'(POOL_SIZE - 1)) ? '0 : r_addr + AW'(1);
    assign abs_rx    = i_rand_x[15] ? 16'(-i_rand_x) : 16'(i_rand_x);
    assign abs_ry    = i_rand_y[15] ? 16'(-i_rand_y) : 16'(i_rand_y);

    // tick and no-op results carry only the hint
    always_comb begin
        res_idle      = '0;
        res_idle.draw = 6'(r_hint);
    end

    // position = emitter + sign * ((|c| * radius) >> 14), saturated
    assign mag_px = r_prx[31:14];
    assign mag_py = r_pry[31:14];
    assign sum_px = 22'(r_ex) + (r_sx ? -$signed({4'b0000, mag_px}) : $signed({4'b0000, mag_px}));
    assign sum_py = 22'(r_ey) + (r_sy ? -$signed({4'b0000, mag_py}) : $signed({4'b0000, mag_py}));

    // ---------------------------------------------------------------- units
    ppu_mem #(
        .DEPTH (POOL_SIZE),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ppu_math u_math (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (math_req),
        .i_a      (math_a),
        .i_b      (math_b),
        .o_sts    (math_sts),
        .o_result (math_res)
    );

    ppu_tick_upd u_tick (
        .i_ent   (mem_rdata),
        .i_dt    (r_dt),
        .i_decay (r_cfg_decay),
        .i_fade  (r_cfg_fade),
        .o_ent   (tick_ent)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppu_pkg::ST_CLEAR: begin
                if (r_idx == IW'(POOL_SIZE - 1)) n_state = ppu_pkg::ST_IDLE;
            end
            ppu_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (ppu_pkg::t_op'(i_op))
                        ppu_pkg::OP_SPAWN: n_state = ppu_pkg::ST_SQ;
                        ppu_pkg::OP_TICK:  n_state = ppu_pkg::ST_TICK;
                        ppu_pkg::OP_READ:  n_state = ppu_pkg::ST_READ;
                        ppu_pkg::OP_NONE:  n_state = ppu_pkg::ST_DONE;
                        default:           n_state = ppu_pkg::ST_DONE;
                    endcase
                end
            end
            ppu_pkg::ST_SQ:   n_state = ppu_pkg::ST_SUM;
            ppu_pkg::ST_SUM:  n_state = ppu_pkg::ST_ROOT;
            ppu_pkg::ST_ROOT: begin
                if (math_sts.done) begin
                    if (!r_clamped && (r_n2[31:28] != 4'd0)) n_state = ppu_pkg::ST_DIVX;
                    else                                     n_state = ppu_pkg::ST_POSM;
                end
            end
            ppu_pkg::ST_DIVX: if (math_sts.done) n_state = ppu_pkg::ST_DIVY;
            ppu_pkg::ST_DIVY: if (math_sts.done) n_state = ppu_pkg::ST_SQ;
            ppu_pkg::ST_POSM: n_state = ppu_pkg::ST_POSS;
            ppu_pkg::ST_POSS: n_state = ppu_pkg::ST_VELM;
            ppu_pkg::ST_VELM: begin
                n_state = (r_root == 16'd0) ? ppu_pkg::ST_SCAN : ppu_pkg::ST_VDIVX;
            end
            ppu_pkg::ST_VDIVX: if (math_sts.done) n_state = ppu_pkg::ST_VDIVY;
            ppu_pkg::ST_VDIVY: if (math_sts.done) n_state = ppu_pkg::ST_SCAN;
            ppu_pkg::ST_SCAN: begin
                if (scan_hit || scan_last) n_state = ppu_pkg::ST_WRITE;
            end
            ppu_pkg::ST_WRITE: n_state = ppu_pkg::ST_DONE;
            ppu_pkg::ST_TICK: begin
                if (!r_pend && (r_idx == IW'(POOL_SIZE))) n_state = ppu_pkg::ST_DONE;
            end
            ppu_pkg::ST_READ:  n_state = ppu_pkg::ST_RDATA;
            ppu_pkg::ST_RDATA: n_state = ppu_pkg::ST_DONE;
            ppu_pkg::ST_DONE:  if (out_free) n_state = ppu_pkg::ST_IDLE;
            default:           n_state = ppu_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        o_ready     = (r_state == ppu_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;

        mem_we    = 1'b0;
        mem_waddr = r_paddr;
        mem_wdata = tick_ent;
        mem_re    = 1'b0;
        mem_raddr = r_addr;

        math_state = 1'b0;
        math_req.op = ppu_pkg::MATH_DIV;
        math_a = '0;
        math_b = r_root;

        unique case (r_state)
            ppu_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = '0;
            end
            ppu_pkg::ST_ROOT: begin
                math_state  = 1'b1;
                math_req.op = ppu_pkg::MATH_SQRT;
                math_a      = r_n2;
            end
            ppu_pkg::ST_DIVX: begin
                math_state = 1'b1;
                math_a     = {2'b00, r_ax, 14'd0};
            end
            ppu_pkg::ST_DIVY: begin
                math_state = 1'b1;
                math_a     = {2'b00, r_ay, 14'd0};
            end
            ppu_pkg::ST_VDIVX: begin
                math_state = 1'b1;
                math_a     = 32'(r_numx);
            end
            ppu_pkg::ST_VDIVY: begin
                math_state = 1'b1;
                math_a     = 32'(r_numy);
            end
            ppu_pkg::ST_SCAN: begin
                mem_re = 1'b1;
            end
            ppu_pkg::ST_WRITE: begin
                mem_we         = 1'b1;
                mem_waddr      = r_slot;
                mem_wdata      = r_ent;
                mem_wdata.life = r_cfg_life;
            end
            ppu_pkg::ST_TICK: begin
                mem_re    = (r_idx < IW'(POOL_SIZE));
                mem_raddr = r_idx[AW-1:0];
                mem_we    = r_pend;
            end
            ppu_pkg::ST_READ: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_sidx);
            end
            default: begin
            end
        endcase

        math_req.start = math_state && !r_mwait;
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ppu_pkg::ST_CLEAR;
            r_hint       <= '0;
            r_mwait      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_cfg_life   <= ppu_pkg::RST_SPAWN_LIFE;
            r_cfg_radius <= ppu_pkg::RST_SPAWN_RADIUS;
            r_cfg_launch <= ppu_pkg::RST_LAUNCH_SPEED;
            r_cfg_decay  <= ppu_pkg::RST_SPEED_DECAY;
            r_cfg_fade   <= ppu_pkg::RST_FADE_STEP;
        end else begin
            r_state <= n_state;

            if (math_req.start)     r_mwait <= 1'b1;
            else if (math_sts.done) r_mwait <= 1'b0;

            if (r_state == ppu_pkg::ST_DONE && out_free) r_out_valid <= 1'b1;
            else if (i_ready)                            r_out_valid <= 1'b0;

            if (r_state == ppu_pkg::ST_WRITE) r_hint <= r_slot;

            // walk counter and pending-read flag
            if (in_acc) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == ppu_pkg::ST_CLEAR) begin
                r_idx <= r_idx + IW'(1);
            end else if (r_state == ppu_pkg::ST_SCAN) begin
                r_pend <= 1'b1;
            end else if (r_state == ppu_pkg::ST_TICK) begin
                r_pend <= (r_idx < IW'(POOL_SIZE));
                if (r_idx < IW'(POOL_SIZE)) r_idx <= r_idx + IW'(1);
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (ppu_pkg::t_cfg_idx'(i_cfg_index))
                    ppu_pkg::CFG_SPAWN_LIFE:   r_cfg_life   <= i_cfg_data;
                    ppu_pkg::CFG_SPAWN_RADIUS: r_cfg_radius <= i_cfg_data;
                    ppu_pkg::CFG_LAUNCH_SPEED: r_cfg_launch <= i_cfg_data[11:0];
                    ppu_pkg::CFG_SPEED_DECAY:  r_cfg_decay  <= i_cfg_data;
                    ppu_pkg::CFG_FADE_STEP:    r_cfg_fade   <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dt      <= i_time_step;
            r_sidx    <= i_slot_index;
            r_ex      <= i_emitter_x;
            r_ey      <= i_emitter_y;
            r_sx      <= i_rand_x[15];
            r_sy      <= i_rand_y[15];
            r_ax      <= abs_rx;
            r_ay      <= abs_ry;
            r_clamped <= 1'b0;
            r_addr    <= r_hint;
            r_chk     <= '0;
            r_ent.red   <= i_rand_red;
            r_ent.green <= i_rand_green;
            r_ent.blue  <= i_rand_blue;
            r_ent.vel_x <= '0;
            r_ent.vel_y <= '0;
            r_ent.life  <= '0;
            r_res       <= res_idle;
        end

        unique case (r_state)
            ppu_pkg::ST_SQ: begin
                r_sqx <= 32'(r_ax) * 32'(r_ax);
                r_sqy <= 32'(r_ay) * 32'(r_ay);
            end
            ppu_pkg::ST_SUM: r_n2 <= r_sqx + r_sqy;
            ppu_pkg::ST_ROOT: if (math_sts.done) r_root <= math_res[15:0];
            ppu_pkg::ST_DIVX: if (math_sts.done) r_ax <= math_res[15:0];
            ppu_pkg::ST_DIVY: begin
                if (math_sts.done) begin
                    r_ay      <= math_res[15:0];
                    r_clamped <= 1'b1;
                end
            end
            ppu_pkg::ST_POSM: begin
                r_prx <= 32'(r_ax) * 32'(r_cfg_radius);
                r_pry <= 32'(r_ay) * 32'(r_cfg_radius);
            end
            ppu_pkg::ST_POSS: begin
                r_ent.pos_x <= ppu_pkg::sat_pos(sum_px);
                r_ent.pos_y <= ppu_pkg::sat_pos(sum_py);
            end
            ppu_pkg::ST_VELM: begin
                r_numx <= 28'(r_ax) * 28'(r_cfg_launch);
                r_numy <= 28'(r_ay) * 28'(r_cfg_launch);
            end
            ppu_pkg::ST_VDIVX: begin
                if (math_sts.done)
                    r_ent.vel_x <= r_sx ? -$signed(math_res[13:0]) : $signed(math_res[13:0]);
            end
            ppu_pkg::ST_VDIVY: begin
                if (math_sts.done)
                    r_ent.vel_y <= r_sy ? -$signed(math_res[13:0]) : $signed(math_res[13:0]);
            end
            ppu_pkg::ST_SCAN: begin
                r_addr  <= addr_wrap;
                r_paddr <= r_addr;
                if (r_pend) r_chk <= r_chk + IW'(1);
                if (scan_hit)       r_slot <= r_paddr;
                else if (scan_last) r_slot <= '0;
            end
            ppu_pkg::ST_WRITE: begin
                r_res.slot  <= 6'(r_slot);
                r_res.alive <= (r_cfg_life != 16'd0);
                r_res.life  <= r_cfg_life;
                r_res.pos_x <= r_ent.pos_x;
                r_res.pos_y <= r_ent.pos_y;
                r_res.red   <= r_ent.red;
                r_res.green <= r_ent.green;
                r_res.blue  <= r_ent.blue;
                r_res.draw  <= 6'(r_slot);
            end
            ppu_pkg::ST_TICK: begin
                r_paddr <= r_idx[AW-1:0];
            end
            ppu_pkg::ST_RDATA: begin
                r_res.slot <= r_sidx;
                if (32'(r_sidx) < POOL_SIZE) begin
                    r_res.alive <= (mem_rdata.life != 16'd0);
                    r_res.life  <= mem_rdata.life;
                    r_res.pos_x <= mem_rdata.pos_x;
                    r_res.pos_y <= mem_rdata.pos_y;
                    r_res.red   <= mem_rdata.red;
                    r_res.green <= mem_rdata.green;
                    r_res.blue  <= mem_rdata.blue;
                end
            end
            ppu_pkg::ST_DONE: begin
                if (out_free) r_out <= r_res;
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_slot       = r_out.slot;
    assign o_alive      = r_out.alive;
    assign o_life_left  = r_out.life;
    assign o_pos_x      = r_out.pos_x;
    assign o_pos_y      = r_out.pos_y;
    assign o_red        = r_out.red;
    assign o_green      = r_out.green;
    assign o_blue       = r_out.blue;
    assign o_draw_start = r_out.draw;

    // ---------------------------------------------------------------- checks
    // tick reads slot i while writing back slot i-1: never the same entry
    `PPU_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "pool read/write clash")
    `PPU_ASSERT_IMP(a_hint_in_pool, 1'b1, 32'(r_hint) < POOL_SIZE, "search hint outside pool")
    `PPU_ASSERT_IMP(a_accept_math_idle, in_acc, !math_sts.busy && !r_mwait, "item taken while math busy")
    `PPU_ASSERT_NXT(a_spawn_sets_hint, r_state == ppu_pkg::ST_WRITE, r_hint == $past(r_slot), "hint not updated by spawn")

endmodule

FILE: hw/rtl/ppu_mem.sv
// Pool storage: one write port, one read port with registered read data.
module ppu_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 120
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ppu_math.sv
// Shared iterative unit: floor square root (2 bits/cycle) and unsigned divide (1 bit/cycle).
module ppu_math (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppu_pkg::t_math_req i_req,
    input  logic [31:0]        i_a,
    input  logic [15:0]        i_b,
    output ppu_pkg::t_math_sts o_sts,
    output logic [31:0]        o_result
);

    logic               r_busy;
    logic               r_done;
    ppu_pkg::t_math_op  r_op;
    logic [4:0]         r_cnt;
    logic [31:0]        r_a;
    logic [15:0]        r_b;
    logic [19:0]        r_rem;
    logic [31:0]        r_q;

    logic [19:0] n_rem;
    logic [31:0] n_q;
    logic [31:0] n_a;
    logic [19:0] shifted;
    logic [19:0] trial;

    always_comb begin
        if (r_op == ppu_pkg::MATH_SQRT) begin
            shifted = {r_rem[17:0], r_a[31:30]};
            trial   = {2'b00, r_q[15:0], 2'b01};
            n_a     = {r_a[29:0], 2'b00};
        end else begin
            shifted = {r_rem[18:0], r_a[31]};
            trial   = {4'b0000, r_b};
            n_a     = {r_a[30:0], 1'b0};
        end
        if (shifted >= trial) begin
            n_rem = shifted - trial;
            n_q   = {r_q[30:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_q   = {r_q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= (i_req.op == ppu_pkg::MATH_SQRT) ? 5'd15 : 5'd31;
        end else if (r_busy) begin
            r_a   <= n_a;
            r_rem <= n_rem;
            r_q   <= n_q;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_q;

endmodule

FILE: hw/rtl/ppu_tick_upd.sv
// Per-slot tick update: life countdown, move, speed decay, color fade.
module ppu_tick_upd (
    input  ppu_pkg::t_entry i_ent,
    input  logic [15:0]     i_dt,
    input  logic [15:0]     i_decay,
    input  logic [11:0]     i_fade,
    output ppu_pkg::t_entry o_ent
);

    logic [15:0]        life_n;
    logic signed [21:0] sum_x;
    logic signed [21:0] sum_y;
    logic [13:0]        mag_x;
    logic [13:0]        mag_y;
    logic [29:0]        prod_x;
    logic [29:0]        prod_y;
    logic               fade_ok;

    always_comb begin
        life_n  = (i_ent.life > i_dt) ? (i_ent.life - i_dt) : 16'd0;
        sum_x   = 22'(i_ent.pos_x) + 22'(i_ent.vel_x);
        sum_y   = 22'(i_ent.pos_y) + 22'(i_ent.vel_y);
        mag_x   = i_ent.vel_x[13] ? 14'(-i_ent.vel_x) : 14'(i_ent.vel_x);
        mag_y   = i_ent.vel_y[13] ? 14'(-i_ent.vel_y) : 14'(i_ent.vel_y);
        prod_x  = 30'(mag_x) * 30'(i_decay);
        prod_y  = 30'(mag_y) * 30'(i_decay);
        fade_ok = (i_ent.red > i_fade) && (i_ent.green > i_fade) && (i_ent.blue > i_fade);

        o_ent      = i_ent;
        o_ent.life = life_n;
        if (life_n != 16'd0) begin
            o_ent.pos_x = ppu_pkg::sat_pos(sum_x);
            o_ent.pos_y = ppu_pkg::sat_pos(sum_y);
            // truncate toward zero: scale the magnitude, then restore the sign
            o_ent.vel_x = i_ent.vel_x[13] ? -$signed(prod_x[29:16]) : $signed(prod_x[29:16]);
            o_ent.vel_y = i_ent.vel_y[13] ? -$signed(prod_y[29:16]) : $signed(prod_y[29:16]);
            if (fade_ok) begin
                o_ent.red   = i_ent.red - i_fade;
                o_ent.green = i_ent.green - i_fade;
                o_ent.blue  = i_ent.blue - i_fade;
            end
        end
    end

endmodule
